[hw/rtl/ttu_pkg.sv]
// ttu_pkg: types, constants and helpers for the triangle tangent unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ttu_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int FIELD_BITS = 16;                 // width of each input field
   localparam int DIFF_BITS  = FIELD_BITS + 1;     // edges and uv differences
   localparam int PROD_BITS  = 2 * DIFF_BITS;      // one shared product
   localparam int WIDE_BITS  = PROD_BITS + 1;      // det and numerators
   localparam int QUOT_SHIFT = 22;                 // aligns Q.22 / Q.28 to Q16.16
   localparam int OUT_BITS   = 32;
   localparam int QUOT_BITS  = OUT_BITS - 1;       // quotient bits below saturation
   localparam int DVD_BITS   = WIDE_BITS + QUOT_SHIFT + 1;
   localparam int HEAD_BITS  = DVD_BITS - QUOT_BITS;
   localparam int MUL_STEPS  = 8;                  // two products for det, two per component
   localparam int NUM_COMP   = 3;

   localparam logic [OUT_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [OUT_BITS-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] pos_x;
      logic signed [FIELD_BITS-1:0] pos_y;
      logic signed [FIELD_BITS-1:0] pos_z;
      logic signed [FIELD_BITS-1:0] tex_u;
      logic signed [FIELD_BITS-1:0] tex_v;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] tangent_x;
      logic signed [OUT_BITS-1:0] tangent_y;
      logic signed [OUT_BITS-1:0] tangent_z;
      logic                       degenerate;
      logic                       last_of_triangle;
   } rsp_payload_type;

   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [WIDE_BITS-1:0] dividend;
      logic [WIDE_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [OUT_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_LOAD,
      DIV_ITER,
      DIV_DONE
   } div_state_type;

   function automatic logic [WIDE_BITS-1:0] mag_wide(input logic signed [WIDE_BITS-1:0] x);
      return x[WIDE_BITS-1] ? WIDE_BITS'(-x) : WIDE_BITS'(x);
   endfunction

endpackage

[hw/rtl/ttu_div.sv]
// ttu_div: restoring divider, one quotient bit per cycle, rounded and saturated
// to signed Q16.16. Depends on ttu_pkg.
`timescale 1ns / 1ps

module ttu_div import ttu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   div_state_type state_ff, state_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [HEAD_BITS-1:0]  head_ff;
   logic [QUOT_BITS-1:0]  lo_ff;
   logic [WIDE_BITS-1:0]  dvs_ff;
   logic [WIDE_BITS-1:0]  rem_ff;
   logic [QUOT_BITS-1:0]  q_ff;
   logic                  neg_ff;
   logic                  ovf_ff;

   logic [DVD_BITS-1:0]   dvd;
   logic [WIDE_BITS:0]    trial;
   logic                  fits;

   // dividend with the half-divisor added gives round to nearest, ties away
   assign dvd   = {1'b0, div_req.dividend, QUOT_SHIFT'(0)}
                + DVD_BITS'(div_req.divisor >> 1);
   assign trial = {rem_ff, lo_ff[QUOT_BITS-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      div_rsp.done = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) begin
               state_in = DIV_LOAD;
            end
         end
         DIV_LOAD: begin
            cnt_in   = '0;
            state_in = DIV_ITER;
         end
         DIV_ITER: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(QUOT_BITS - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            div_rsp.done = 1'b1;
            state_in     = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
      if (ovf_ff) begin
         div_rsp.quotient = neg_ff ? SAT_NEG : SAT_POS;
      end else if (neg_ff) begin
         div_rsp.quotient = -$signed({1'b0, q_ff});
      end else begin
         div_rsp.quotient = $signed({1'b0, q_ff});
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         DIV_IDLE: begin
            head_ff <= dvd[DVD_BITS-1:QUOT_BITS];
            lo_ff   <= dvd[QUOT_BITS-1:0];
            dvs_ff  <= div_req.divisor;
            neg_ff  <= div_req.neg;
         end
         DIV_LOAD: begin
            // quotient of 2^31 or more saturates either way
            ovf_ff <= WIDE_BITS'(head_ff) >= dvs_ff;
            rem_ff <= WIDE_BITS'(head_ff);
         end
         DIV_ITER: begin
            rem_ff <= fits ? WIDE_BITS'(trial - {1'b0, dvs_ff}) : trial[WIDE_BITS-1:0];
            q_ff   <= {q_ff[QUOT_BITS-2:0], fits};
            lo_ff  <= {lo_ff[QUOT_BITS-2:0], 1'b0};
         end
         DIV_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

[hw/rtl/triangle_tangent_from_uv_unit.sv]
// Channel  Dir  Payload            Handshake
// req      in   req_payload_type   req_valid / req_stall, one vertex a beat
// rsp      out  rsp_payload_type   rsp_valid / rsp_stall, three beats a triangle
//
// First and second vertex of a triangle: no result.
// Third vertex: products on the shared 17x17 multiplier, then three runs of the
// 31-step divider, then 3 result beats.
// Zero determinant skips the divider.
// req_stall is high from the third vertex until its last beat is taken.
// Synchronous reset returns to vertex 0 with no result pending.
// Top level of the tangent unit. Depends on ttu_pkg and ttu_div.
`timescale 1ns / 1ps

module triangle_tangent_from_uv_unit import ttu_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int EFF_BITS = (COORD_BITS > FIELD_BITS) ? FIELD_BITS : COORD_BITS;
   localparam int EXT_SH   = FIELD_BITS - EFF_BITS;

   function automatic logic signed [FIELD_BITS-1:0] sext(input logic [FIELD_BITS-1:0] f);
      logic signed [FIELD_BITS-1:0] t;
      t = f << EXT_SH;
      return t >>> EXT_SH;
   endfunction

   top_state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] mstep_ff, mstep_in;
   logic [1:0] cidx_ff, cidx_in;
   logic [1:0] beat_ff, beat_in;

   req_payload_type cur;
   req_payload_type held_ff [2];

   logic signed [DIFF_BITS-1:0] e0_ff [NUM_COMP];
   logic signed [DIFF_BITS-1:0] e1_ff [NUM_COMP];
   logic signed [DIFF_BITS-1:0] d0u_ff, d0v_ff, d1u_ff, d1v_ff;

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [WIDE_BITS-1:0] acc_ff, diff;
   logic signed [WIDE_BITS-1:0] det_ff;
   logic signed [WIDE_BITS-1:0] num_ff [NUM_COMP];
   logic                        degen_ff;
   logic signed [OUT_BITS-1:0]  tan_ff [NUM_COMP];

   logic signed [DIFF_BITS-1:0] op_a, op_b;
   logic [1:0] kidx;
   logic [2:0] jstep;
   logic [1:0] nidx;
   logic       accept;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign accept = req_valid && !req_stall;
   assign cur.pos_x = sext(req_data.pos_x);
   assign cur.pos_y = sext(req_data.pos_y);
   assign cur.pos_z = sext(req_data.pos_z);
   assign cur.tex_u = sext(req_data.tex_u);
   assign cur.tex_v = sext(req_data.tex_v);

   // product order: d0u*d1v, d0v*d1u, then d1v*e0[k], d0v*e1[k] per component
   assign kidx  = (mstep_ff[2:1] == 2'd0) ? 2'd0 : mstep_ff[2:1] - 2'd1;
   assign op_a  = (mstep_ff[2:0] == 3'd0) ? d0u_ff : (mstep_ff[0] ? d0v_ff : d1v_ff);
   always_comb begin
      priority if (mstep_ff[2:0] == 3'd0) begin
         op_b = d1v_ff;
      end else if (mstep_ff[2:0] == 3'd1) begin
         op_b = d1u_ff;
      end else if (!mstep_ff[0]) begin
         op_b = e0_ff[kidx];
      end else begin
         op_b = e1_ff[kidx];
      end
   end
   assign prod_in = op_a * op_b;

   assign jstep = mstep_ff[2:0] - 3'd1;
   assign nidx  = jstep[2:1] - 2'd1;
   assign diff  = acc_ff - WIDE_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      mstep_ff <= mstep_in;
      cidx_ff  <= cidx_in;
      beat_ff  <= beat_in;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      mstep_in = mstep_ff;
      cidx_in  = cidx_ff;
      beat_in  = beat_ff;
      div_req.start    = 1'b0;
      div_req.neg      = num_ff[cidx_ff][WIDE_BITS-1] != det_ff[WIDE_BITS-1];
      div_req.dividend = mag_wide(num_ff[cidx_ff]);
      div_req.divisor  = mag_wide(det_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (phase_ff == 2'd2) begin
                  phase_in = '0;
                  mstep_in = '0;
                  state_in = ST_MUL;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 4'd1;
            if (mstep_ff == 4'(MUL_STEPS)) begin
               cidx_in  = '0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            if (degen_ff) begin
               beat_in  = '0;
               state_in = ST_OUT;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (cidx_ff == 2'(NUM_COMP - 1)) begin
                  beat_in  = '0;
                  state_in = ST_OUT;
               end else begin
                  cidx_in  = cidx_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (beat_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  beat_in = beat_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (phase_ff != 2'd2) begin
            held_ff[phase_ff[0]] <= cur;
         end else begin
            e0_ff[0] <= DIFF_BITS'(held_ff[1].pos_x) - DIFF_BITS'(held_ff[0].pos_x);
            e0_ff[1] <= DIFF_BITS'(held_ff[1].pos_y) - DIFF_BITS'(held_ff[0].pos_y);
            e0_ff[2] <= DIFF_BITS'(held_ff[1].pos_z) - DIFF_BITS'(held_ff[0].pos_z);
            e1_ff[0] <= DIFF_BITS'(cur.pos_x) - DIFF_BITS'(held_ff[0].pos_x);
            e1_ff[1] <= DIFF_BITS'(cur.pos_y) - DIFF_BITS'(held_ff[0].pos_y);
            e1_ff[2] <= DIFF_BITS'(cur.pos_z) - DIFF_BITS'(held_ff[0].pos_z);
            d0u_ff   <= DIFF_BITS'(held_ff[1].tex_u) - DIFF_BITS'(held_ff[0].tex_u);
            d0v_ff   <= DIFF_BITS'(held_ff[1].tex_v) - DIFF_BITS'(held_ff[0].tex_v);
            d1u_ff   <= DIFF_BITS'(cur.tex_u) - DIFF_BITS'(held_ff[0].tex_u);
            d1v_ff   <= DIFF_BITS'(cur.tex_v) - DIFF_BITS'(held_ff[0].tex_v);
         end
      end
      if (state_ff == ST_MUL) begin
         if (mstep_ff != 4'(MUL_STEPS)) begin
            prod_ff <= prod_in;
         end
         // one step behind the multiplier: even products load, odd ones subtract
         if (mstep_ff != 4'd0) begin
            if (!jstep[0]) begin
               acc_ff <= WIDE_BITS'(prod_ff);
            end else if (jstep == 3'd1) begin
               det_ff   <= diff;
               degen_ff <= diff == '0;
            end else begin
               num_ff[nidx] <= diff;
            end
         end
      end
      if (state_ff == ST_DIV_GO && degen_ff) begin
         for (int k = 0; k < NUM_COMP; k++) begin
            tan_ff[k] <= '0;
         end
      end
      if (state_ff == ST_DIV_WAIT && div_rsp.done) begin
         tan_ff[cidx_ff] <= div_rsp.quotient;
      end
   end

   ttu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;

   assign rsp_data.tangent_x        = tan_ff[0];
   assign rsp_data.tangent_y        = tan_ff[1];
   assign rsp_data.tangent_z        = tan_ff[2];
   assign rsp_data.degenerate       = degen_ff;
   assign rsp_data.last_of_triangle = beat_ff == 2'd2;

endmodule

[hw/rtl/ttu_check.sv]
// ttu_check: port-level checks for the tangent unit, bound to the top level.
// Depends on ttu_pkg.
`timescale 1ns / 1ps

module ttu_check import ttu_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // no vertex is taken while a triangle's beats are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("vertex accepted while results pending");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.tangent_x == '0 && rsp_data.tangent_y == '0 && rsp_data.tangent_z == '0)
      else $error("degenerate triangle with non-zero tangent");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_of_triangle |=> !rsp_valid)
      else $error("result beat after last of triangle");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind triangle_tangent_from_uv_unit ttu_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/testbench.sv]
// testbench: directed and random vertex streams into the tangent unit, with a
// built-in predictor and an in-order scoreboard of the expected tangent beats.
// Depends on ttu_pkg and triangle_tangent_from_uv_unit.
`timescale 1ns / 1ps

module testbench;
   import ttu_pkg::*;

   localparam int COORD_BITS    = 16;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 150;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_FACES  = 69;

   typedef struct {
      req_payload_type beat;
      int unsigned     gap;
      bit              drain;
   } vertex_job_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   vertex_job_type  vertex_jobs[$];
   rsp_payload_type tangents_due[$];

   // predictor copy of the held corners
   longint          corner_pos[2][3];
   longint          corner_uv[2][2];
   int unsigned     corner_count = 0;

   logic            req_fire = 1'b0;
   logic            rsp_fire = 1'b0;
   int unsigned     req_gap = 0;
   int unsigned     rsp_hold = 0;
   bit              rsp_calm = 1'b0;
   bit              calm_sender = 1'b0;
   int unsigned     idle_cycles = 0;
   int unsigned     mismatches = 0;

   triangle_tangent_from_uv_unit #(.COORD_BITS(COORD_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // low COORD_BITS of the field as two's complement, capped at the field width
   function automatic longint field_value(input logic [15:0] raw);
      int unsigned       eff;
      longint unsigned   m;
      eff = (COORD_BITS > 16) ? 16 : COORD_BITS;
      m = longint'(raw) & ((64'd1 << eff) - 64'd1);
      if (m[eff-1]) return longint'(m) - (longint'(1) << eff);
      return longint'(m);
   endfunction

   // numerator Q.22 over det Q.28, rounded half away from zero, saturated Q16.16
   function automatic logic [31:0] q16_quotient(input longint num, input longint det);
      longint unsigned un, ud, q;
      bit              neg;
      un = (num < 0) ? -num : num;
      ud = (det < 0) ? -det : det;
      neg = (num < 0) != (det < 0);
      q = ((un << QUOT_SHIFT) + (ud >> 1)) / ud;
      if (q == 0) return '0;
      if (neg) return (q >= 64'h8000_0000) ? SAT_NEG : 32'(-q);
      return (q > 64'h7FFF_FFFF) ? SAT_POS : q[31:0];
   endfunction

   task automatic account_vertex(input req_payload_type v);
      longint          p[3], t[2], e0[3], e1[3], d0[2], d1[2], det;
      rsp_payload_type r;
      p[0] = field_value(v.pos_x);
      p[1] = field_value(v.pos_y);
      p[2] = field_value(v.pos_z);
      t[0] = field_value(v.tex_u);
      t[1] = field_value(v.tex_v);
      if (corner_count < 2) begin
         corner_pos[corner_count] = p;
         corner_uv[corner_count] = t;
         corner_count++;
      end else begin
         corner_count = 0;
         for (int k = 0; k < 3; k++) begin
            e0[k] = corner_pos[1][k] - corner_pos[0][k];
            e1[k] = p[k] - corner_pos[0][k];
         end
         for (int k = 0; k < 2; k++) begin
            d0[k] = corner_uv[1][k] - corner_uv[0][k];
            d1[k] = t[k] - corner_uv[0][k];
         end
         det = d0[0] * d1[1] - d0[1] * d1[0];
         r = '0;
         r.degenerate = (det == 0);
         if (det != 0) begin
            r.tangent_x = q16_quotient(d1[1] * e0[0] - d0[1] * e1[0], det);
            r.tangent_y = q16_quotient(d1[1] * e0[1] - d0[1] * e1[1], det);
            r.tangent_z = q16_quotient(d1[1] * e0[2] - d0[1] * e1[2], det);
         end
         for (int i = 0; i < 3; i++) begin
            r.last_of_triangle = (i == 2);
            tangents_due = {tangents_due, r};
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   task automatic add_vertex(input logic [15:0] px, py, pz, tu, tv,
                             input bit drain = 1'b0);
      vertex_job_type job;
      job.beat = {px, py, pz, tu, tv};
      job.gap = calm_sender ? 0 : $urandom_range(0, 15);
      job.drain = drain;
      vertex_jobs = {vertex_jobs, job};
   endtask

   function automatic logic [15:0] nudge(input int unsigned span);
      return 16'($urandom_range(0, 2 * span)) - 16'(span);
   endfunction

   // sender: holds a beat until taken, then waits its gap before the next
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || req_fire) begin
         if (vertex_jobs.size() == 0 ||
             (vertex_jobs[0].drain && tangents_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (req_gap < vertex_jobs[0].gap) begin
            req_valid <= 1'b0;
            req_gap <= req_gap + 1;
         end else begin
            req_valid <= 1'b1;
            req_data <= vertex_jobs[0].beat;
            req_gap <= 0;
            void'(vertex_jobs.pop_front());
         end
      end
   end

   // receiver: after each beat, stall for a drawn number of valid cycles
   always @(negedge clock) begin
      int unsigned h;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else begin
         h = rsp_hold;
         if (rsp_fire) begin
            h = rsp_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 15) == 0) rsp_calm <= !rsp_calm;
         end
         rsp_stall <= (h != 0);
         rsp_hold <= (rsp_valid && h != 0) ? h - 1 : h;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) account_vertex(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (tangents_due.size() == 0) begin
               report_mismatch("beat with nothing due, tangent_x", '0, rsp_data.tangent_x);
            end else begin
               want = tangents_due.pop_front();
               if (rsp_data.tangent_x !== want.tangent_x)
                  report_mismatch("tangent_x", want.tangent_x, rsp_data.tangent_x);
               if (rsp_data.tangent_y !== want.tangent_y)
                  report_mismatch("tangent_y", want.tangent_y, rsp_data.tangent_y);
               if (rsp_data.tangent_z !== want.tangent_z)
                  report_mismatch("tangent_z", want.tangent_z, rsp_data.tangent_z);
               if (rsp_data.degenerate !== want.degenerate)
                  report_mismatch("degenerate", want.degenerate, rsp_data.degenerate);
               if (rsp_data.last_of_triangle !== want.last_of_triangle)
                  report_mismatch("last_of_triangle", want.last_of_triangle,
                                  rsp_data.last_of_triangle);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] fld [3][5];
      logic [15:0] rim_vals [5];
      int unsigned kind;
      bit          timed_out;
      timed_out = 1'b0;
      rim_vals[0] = 16'h8000;
      rim_vals[1] = 16'h7FFF;
      rim_vals[2] = 16'h0000;
      rim_vals[3] = 16'hFFFF;
      rim_vals[4] = 16'h0001;

      // unit tangent along x
      add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_vertex(16'h0100, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
      add_vertex(16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h4000);
      // identical uvs: degenerate
      add_vertex(16'd100, 16'd200, 16'd300, 16'h1234, 16'h1234);
      add_vertex(16'd400, 16'hFFFB, 16'd7, 16'h1234, 16'h1234);
      add_vertex(16'd9, 16'd9, 16'd9, 16'h1234, 16'h1234);
      // distinct but collinear uvs: degenerate
      add_vertex(16'h0300, 16'hF000, 16'h0042, 16'h0000, 16'h0000);
      add_vertex(16'h1100, 16'h0020, 16'hC000, 16'h0002, 16'h0004);
      add_vertex(16'hA5A5, 16'h5A5A, 16'h0F0F, 16'h0001, 16'h0002);
      // field extremes, sent only once the unit has gone quiet
      add_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      add_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
      add_vertex(16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF);
      // unit det with full-scale edges: saturates both ways
      add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_vertex(16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
      add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
      // negative det
      add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_vertex(16'h0100, 16'h0200, 16'hFF00, 16'h0000, 16'h4000);
      add_vertex(16'h0080, 16'h0000, 16'h0040, 16'h4000, 16'h0000);
      // coincident positions: zero tangent, not degenerate
      add_vertex(16'h1111, 16'h1111, 16'h1111, 16'h0000, 16'h0000);
      add_vertex(16'h1111, 16'h1111, 16'h1111, 16'h4000, 16'h0000);
      add_vertex(16'h1111, 16'h1111, 16'h1111, 16'h0000, 16'h4000);
      // mixed signs
      add_vertex(16'hFF00, 16'h0080, 16'h0300, 16'h2000, 16'hE000);
      add_vertex(16'h0180, 16'hFE40, 16'h0010, 16'hC000, 16'h1000);
      add_vertex(16'h7000, 16'h9000, 16'h0001, 16'h1800, 16'h3FFF);

      for (int face_idx = 0; face_idx < RANDOM_FACES; face_idx++) begin
         calm_sender = (face_idx >= 25 && face_idx < 35);
         kind = $urandom_range(0, 9);
         for (int c = 0; c < 3; c++)
            for (int f = 0; f < 5; f++)
               fld[c][f] = 16'($urandom);
         case (kind)
            5, 6: begin
               // tiny uv spread: large tangents, often saturated
               for (int c = 1; c < 3; c++)
                  for (int f = 3; f < 5; f++)
                     fld[c][f] = fld[0][f] + nudge(3);
            end
            7: begin
               fld[2][3] = fld[0][3];
               fld[2][4] = fld[0][4];
               if ($urandom_range(0, 1)) begin
                  fld[1][3] = fld[0][3];
                  fld[1][4] = fld[0][4];
               end
            end
            8: begin
               for (int c = 1; c < 3; c++)
                  for (int f = 0; f < 3; f++)
                     fld[c][f] = fld[0][f] + nudge(255);
            end
            9: begin
               for (int c = 0; c < 3; c++)
                  for (int f = 0; f < 5; f++)
                     fld[c][f] = rim_vals[$urandom_range(0, 4)];
            end
            default: ;
         endcase
         for (int c = 0; c < 3; c++)
            add_vertex(fld[c][0], fld[c][1], fld[c][2], fld[c][3], fld[c][4],
                       c == 0 && face_idx % 16 == 8);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!timed_out &&
             (vertex_jobs.size() != 0 || req_valid || tangents_due.size() != 0)) begin
         @(posedge clock);
         if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
      end
      if (!timed_out) repeat (SETTLE_CYCLES) @(posedge clock);

      if (!timed_out && mismatches == 0 && tangents_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
